// ===== rtl/core/spc_pkg.sv =====
package spc_pkg;

    localparam int IDX_W    = 4;
    localparam int CUST_W   = 16;
    localparam int IN_T_W   = 16;
    localparam int LEAVE_W  = 18;
    localparam int CNT_W    = 5;
    localparam int CFG_W    = 5;
    localparam int CMP_W    = 7;

    localparam int DEF_MAX_SERVERS = 16;
    localparam int DEF_TIME_BITS   = 16;

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DEPART = 1'b1;

    // what the head unit reports about the server passing through it
    typedef struct packed {
        logic in_use;
        logic busy;
        logic depart;
    } t_head_evt;

endpackage

// ===== rtl/core/spc_cell.sv =====
module spc_cell #(
    parameter int TIME_BITS = spc_pkg::DEF_TIME_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_busy,
    input  logic [TIME_BITS-1:0]        i_rem,
    input  logic [spc_pkg::CUST_W-1:0]  i_cust,
    input  logic [spc_pkg::LEAVE_W-1:0] i_leave,
    output logic                        o_busy,
    output logic [TIME_BITS-1:0]        o_rem,
    output logic [spc_pkg::CUST_W-1:0]  o_cust,
    output logic [spc_pkg::LEAVE_W-1:0] o_leave
);
    import spc_pkg::*;

    logic                r_busy;
    logic [TIME_BITS-1:0] r_rem;
    logic [CUST_W-1:0]   r_cust;
    logic [LEAVE_W-1:0]  r_leave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_shift) begin
            r_busy <= i_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rem   <= i_rem;
            r_cust  <= i_cust;
            r_leave <= i_leave;
        end
    end

    assign o_busy  = r_busy;
    assign o_rem   = r_rem;
    assign o_cust  = r_cust;
    assign o_leave = r_leave;

endmodule

// ===== rtl/core/spc_head.sv =====
module spc_head #(
    parameter int TIME_BITS = spc_pkg::DEF_TIME_BITS,
    parameter int SW        = 4
) (
    input  logic [SW-1:0]               i_step,
    input  logic [spc_pkg::CFG_W-1:0]   i_n,
    input  logic                        i_cmd,
    input  logic [spc_pkg::IDX_W-1:0]   i_idx,
    input  logic [spc_pkg::CUST_W-1:0]  i_new_cust,
    input  logic [spc_pkg::LEAVE_W-1:0] i_new_leave,
    input  logic [TIME_BITS-1:0]        i_load,
    input  logic                        i_busy,
    input  logic [TIME_BITS-1:0]        i_rem,
    input  logic [spc_pkg::CUST_W-1:0]  i_cust,
    input  logic [spc_pkg::LEAVE_W-1:0] i_leave,
    output logic                        o_busy,
    output logic [TIME_BITS-1:0]        o_rem,
    output logic [spc_pkg::CUST_W-1:0]  o_cust,
    output logic [spc_pkg::LEAVE_W-1:0] o_leave,
    output spc_pkg::t_head_evt          o_evt
);
    import spc_pkg::*;

    logic                 in_use;
    logic [TIME_BITS-1:0] rem_dec;

    assign in_use  = CMP_W'(i_step) < CMP_W'(i_n);
    assign rem_dec = i_rem - TIME_BITS'(1);

    always_comb begin
        o_busy     = i_busy;
        o_rem      = i_rem;
        o_cust     = i_cust;
        o_leave    = i_leave;
        o_evt      = '0;
        if (in_use) begin
            if (i_cmd == CMD_ASSIGN) begin
                // zero service time never frees, so it is dropped
                if (CMP_W'(i_step) == CMP_W'(i_idx) && i_load != '0) begin
                    o_busy  = 1'b1;
                    o_rem   = i_load;
                    o_cust  = i_new_cust;
                    o_leave = i_new_leave;
                end
            end else if (i_busy) begin
                o_rem = rem_dec;
                if (rem_dec == '0) begin
                    o_busy       = 1'b0;
                    o_evt.depart = 1'b1;
                end
            end
        end
        o_evt.in_use = in_use;
        o_evt.busy   = o_busy;
    end

endmodule

// ===== rtl/core/server_pool_countdown_core.sv =====
// Server pool with per-server service countdown.
// Input channel (i_s_*): tuser is the command (assign or tick), tdata the
// server index, customer, arrival, waiting and transaction times.
// Config channel (i_cfg_*): servers_in_use, always ready; write it only
// while the block is idle.
// Output channel (o_m_*): tuser is the result kind (status or departure),
// tlast marks the status result that closes every item.
// Servers sit in a ring of cells that rotates by one each cycle while
// an item is walked and the output is not stalled; the server at the
// ring head is updated on its way around, so departures come out in
// ascending server order. Departures are registered in S_RUN and the
// status result in S_STAT; a new item is taken only back in S_IDLE, so
// one item is through before the next is taken.
// A stall on o_m_tready freezes the ring until the waiting result is
// taken. Reset frees all servers and sets servers_in_use to 1.
module server_pool_countdown_core #(
    parameter int MAX_SERVERS = spc_pkg::DEF_MAX_SERVERS,
    parameter int TIME_BITS   = spc_pkg::DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] server_index, [19:4] customer_number, [35:20] arrival_time,
    // [51:36] waiting_time, [67:52] transaction_time, [71:68] zero
    input  logic [71:0] i_s_tdata,
    // [0] cmd
    input  logic        i_s_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [spc_pkg::CFG_W-1:0] i_cfg_data,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] departed_server, [19:4] departed_customer, [37:20] departure_time,
    // [38] free_found, [42:39] first_free_server, [47:43] busy_count
    output logic [47:0] o_m_tdata,
    // [0] result_kind
    output logic        o_m_tuser,
    output logic        o_m_tlast
);
    import spc_pkg::*;

    localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int LIM = (MAX_SERVERS < 16) ? MAX_SERVERS : 16;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_STAT} t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_servers_in_use;
    logic [CFG_W-1:0]     n_eff;
    logic [SW-1:0]        r_step;
    logic                 r_cmd;
    logic [IDX_W-1:0]     r_idx;
    logic [CUST_W-1:0]    r_new_cust;
    logic [LEAVE_W-1:0]   r_new_leave;
    logic [TIME_BITS-1:0] r_load;
    logic [CNT_W-1:0]     r_busy_cnt;
    logic                 r_found;
    logic [IDX_W-1:0]     r_first;

    logic                 r_out_valid;
    logic                 r_kind;
    logic                 r_last;
    logic [IDX_W-1:0]     r_o_srv;
    logic [CUST_W-1:0]    r_o_cust;
    logic [LEAVE_W-1:0]   r_o_leave;
    logic                 r_o_found;
    logic [IDX_W-1:0]     r_o_first;
    logic [CNT_W-1:0]     r_o_busy;

    logic                 s_accept;
    logic                 go;
    logic                 shift;

    logic                 c_busy  [MAX_SERVERS];
    logic [TIME_BITS-1:0] c_rem   [MAX_SERVERS];
    logic [CUST_W-1:0]    c_cust  [MAX_SERVERS];
    logic [LEAVE_W-1:0]   c_leave [MAX_SERVERS];

    logic                 h_busy;
    logic [TIME_BITS-1:0] h_rem;
    logic [CUST_W-1:0]    h_cust;
    logic [LEAVE_W-1:0]   h_leave;
    t_head_evt            h_evt;

    assign n_eff       = (r_servers_in_use > CFG_W'(LIM)) ? CFG_W'(LIM) : r_servers_in_use;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign go          = !r_out_valid || i_m_tready;
    assign shift       = (r_state == S_RUN) && go;

    // ring: cell k takes cell k+1, the last cell takes the head result
    for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_ring
        if (k == MAX_SERVERS - 1) begin : g_tail
            spc_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_busy  (h_busy),
                .i_rem   (h_rem),
                .i_cust  (h_cust),
                .i_leave (h_leave),
                .o_busy  (c_busy[k]),
                .o_rem   (c_rem[k]),
                .o_cust  (c_cust[k]),
                .o_leave (c_leave[k])
            );
        end else begin : g_body
            spc_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_busy  (c_busy[k+1]),
                .i_rem   (c_rem[k+1]),
                .i_cust  (c_cust[k+1]),
                .i_leave (c_leave[k+1]),
                .o_busy  (c_busy[k]),
                .o_rem   (c_rem[k]),
                .o_cust  (c_cust[k]),
                .o_leave (c_leave[k])
            );
        end
    end

    spc_head #(.TIME_BITS(TIME_BITS), .SW(SW)) u_head (
        .i_step      (r_step),
        .i_n         (n_eff),
        .i_cmd       (r_cmd),
        .i_idx       (r_idx),
        .i_new_cust  (r_new_cust),
        .i_new_leave (r_new_leave),
        .i_load      (r_load),
        .i_busy      (c_busy[0]),
        .i_rem       (c_rem[0]),
        .i_cust      (c_cust[0]),
        .i_leave     (c_leave[0]),
        .o_busy      (h_busy),
        .o_rem       (h_rem),
        .o_cust      (h_cust),
        .o_leave     (h_leave),
        .o_evt       (h_evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servers_in_use <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_servers_in_use <= i_cfg_data;
        end
    end

    // item fields
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd       <= i_s_tuser;
            r_idx       <= i_s_tdata[3:0];
            r_new_cust  <= i_s_tdata[19:4];
            r_load      <= TIME_BITS'(i_s_tdata[67:52]);
            r_new_leave <= LEAVE_W'(i_s_tdata[35:20]) + LEAVE_W'(i_s_tdata[51:36])
                         + LEAVE_W'(i_s_tdata[67:52]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_busy_cnt  <= '0;
            r_found     <= 1'b0;
            r_first     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (s_accept) begin
                        r_state    <= S_RUN;
                        r_step     <= '0;
                        r_busy_cnt <= '0;
                        r_found    <= 1'b0;
                        r_first    <= '0;
                    end
                end
                S_RUN: begin
                    if (go) begin
                        r_out_valid <= h_evt.depart;
                        if (h_evt.in_use) begin
                            if (h_evt.busy) begin
                                r_busy_cnt <= r_busy_cnt + CNT_W'(1);
                            end else if (!r_found) begin
                                r_found <= 1'b1;
                                r_first <= IDX_W'(r_step);
                            end
                        end
                        if (CMP_W'(r_step) == CMP_W'(MAX_SERVERS - 1)) begin
                            r_state <= S_STAT;
                        end else begin
                            r_step <= r_step + SW'(1);
                        end
                    end
                end
                S_STAT: begin
                    if (go) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && go && h_evt.depart) begin
            r_kind    <= KIND_DEPART;
            r_last    <= 1'b0;
            r_o_srv   <= IDX_W'(r_step);
            r_o_cust  <= c_cust[0];
            r_o_leave <= c_leave[0];
            r_o_found <= 1'b0;
            r_o_first <= '0;
            r_o_busy  <= '0;
        end else if (r_state == S_STAT && go) begin
            r_kind    <= KIND_STATUS;
            r_last    <= 1'b1;
            r_o_srv   <= '0;
            r_o_cust  <= '0;
            r_o_leave <= '0;
            r_o_found <= r_found;
            r_o_first <= r_first;
            r_o_busy  <= r_busy_cnt;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {r_o_busy, r_o_first, r_o_found, r_o_leave, r_o_cust, r_o_srv};

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_RUN) && (r_step == '0))
        else $error("item accepted but ring walk did not start at server 0");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_STATUS) == o_m_tlast)
        else $error("tlast does not match result kind");

    a_found_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && r_found) |-> (r_busy_cnt < n_eff))
        else $error("free server reported with all in-use servers busy");

    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT) |-> (r_busy_cnt <= n_eff))
        else $error("busy count above servers in use");

    a_no_walk_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(c_busy[0]) || $past(s_accept) == 1'b0)
        else $error("ring moved while idle");

endmodule
